// ===== rtl/ptpr_pkg.sv =====
package ptpr_pkg;

  // Fraction bits of positions, offsets, weights and results.
  localparam int unsigned FRAC_BITS = 16;
  // Fraction bits of quaternion, rotation entries and normals.
  localparam int unsigned QUAT_FRAC = 30;

  localparam int unsigned NUM_STAGES = 8;

  localparam logic signed [63:0] QUAT_ONE = 64'sd1 <<< QUAT_FRAC;
  localparam logic signed [63:0] SAT_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN  = -64'sd2147483648;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_POSE_TX = 3'd0;
  localparam logic [2:0] REG_POSE_TY = 3'd1;
  localparam logic [2:0] REG_POSE_TZ = 3'd2;
  localparam logic [2:0] REG_QUAT_X  = 3'd3;
  localparam logic [2:0] REG_QUAT_Y  = 3'd4;
  localparam logic [2:0] REG_QUAT_Z  = 3'd5;
  localparam logic [2:0] REG_QUAT_W  = 3'd6;

  // Round to nearest, ties toward +inf.
  function automatic logic signed [63:0] rshift(logic signed [63:0] v, int unsigned s);
    if (s == 0) begin
      return v;
    end
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [63:0] mulq(logic signed [31:0] a,
                                              logic signed [31:0] b,
                                              int unsigned s);
    logic signed [63:0] prod;
    prod = 64'(a) * 64'(b);
    return rshift(prod, s);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > SAT_MAX) begin
      return SAT_MAX[31:0];
    end
    if (v < SAT_MIN) begin
      return SAT_MIN[31:0];
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/point_to_plane_residual_top.sv =====
// Latency: out_valid rises when an accepted input transaction reaches the last
// of the eight register stages; the first stage loads at the edge that accepts it.
// Throughput: one transaction per cycle while out_stall is low; each stage holds one item and the
// stall chain lets a stage fill whenever the one after it moves or is empty.
// Reset (rst, synchronous): clears every stage valid bit and loads the pose
// registers with zero translation and the identity quaternion (w = 1.0).
module point_to_plane_residual_top (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic signed [31:0] normal_z,
  input  logic signed [31:0] plane_offset,
  input  logic [30:0]        weight,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] residual,
  output logic signed [31:0] jac_tx,
  output logic signed [31:0] jac_ty,
  output logic signed [31:0] jac_tz,
  output logic signed [31:0] jac_rx,
  output logic signed [31:0] jac_ry,
  output logic signed [31:0] jac_rz
);

  // ---------------------------------------------------------------------
  // Pose registers. The user must see that they are written only while no transaction
  // is in flight, so the stages read them directly; the block does not enforce this.
  // ---------------------------------------------------------------------
  logic signed [31:0] pose_tx, pose_ty, pose_tz;
  logic signed [31:0] quat_x, quat_y, quat_z, quat_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_tx <= '0;
      pose_ty <= '0;
      pose_tz <= '0;
      quat_x  <= '0;
      quat_y  <= '0;
      quat_z  <= '0;
      quat_w  <= ptpr_pkg::QUAT_ONE[31:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptpr_pkg::REG_POSE_TX: pose_tx <= cfg_data;
        ptpr_pkg::REG_POSE_TY: pose_ty <= cfg_data;
        ptpr_pkg::REG_POSE_TZ: pose_tz <= cfg_data;
        ptpr_pkg::REG_QUAT_X:  quat_x  <= cfg_data;
        ptpr_pkg::REG_QUAT_Y:  quat_y  <= cfg_data;
        ptpr_pkg::REG_QUAT_Z:  quat_z  <= cfg_data;
        ptpr_pkg::REG_QUAT_W:  quat_w  <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage valid bits and the stall chain.
  // rdy[k] means stage k+1 may load this cycle. rdy[NUM_STAGES] is the
  // output side taking (or not stalling) the result.
  // ---------------------------------------------------------------------
  localparam int unsigned NS = ptpr_pkg::NUM_STAGES;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // S1: capture the transaction, quaternion products, normal to QP.
  // ---------------------------------------------------------------------
  logic signed [31:0] s1_p [0:2];
  logic signed [31:0] s1_n [0:2];
  logic signed [31:0] s1_d;
  logic [30:0]        s1_w;
  logic signed [31:0] s1_jt [0:2];
  logic signed [33:0] s1_xx, s1_yy, s1_zz, s1_xy, s1_xz, s1_yz, s1_xw, s1_yw, s1_zw;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_p[0] <= point_x;
      s1_p[1] <= point_y;
      s1_p[2] <= point_z;
      s1_n[0] <= normal_x;
      s1_n[1] <= normal_y;
      s1_n[2] <= normal_z;
      s1_d    <= plane_offset;
      s1_w    <= weight;
      s1_jt[0] <= ptpr_pkg::sat32(ptpr_pkg::rshift(64'(normal_x),
                    ptpr_pkg::QUAT_FRAC - ptpr_pkg::FRAC_BITS));
      s1_jt[1] <= ptpr_pkg::sat32(ptpr_pkg::rshift(64'(normal_y),
                    ptpr_pkg::QUAT_FRAC - ptpr_pkg::FRAC_BITS));
      s1_jt[2] <= ptpr_pkg::sat32(ptpr_pkg::rshift(64'(normal_z),
                    ptpr_pkg::QUAT_FRAC - ptpr_pkg::FRAC_BITS));
      s1_xx <= 34'(ptpr_pkg::mulq(quat_x, quat_x, ptpr_pkg::QUAT_FRAC));
      s1_yy <= 34'(ptpr_pkg::mulq(quat_y, quat_y, ptpr_pkg::QUAT_FRAC));
      s1_zz <= 34'(ptpr_pkg::mulq(quat_z, quat_z, ptpr_pkg::QUAT_FRAC));
      s1_xy <= 34'(ptpr_pkg::mulq(quat_x, quat_y, ptpr_pkg::QUAT_FRAC));
      s1_xz <= 34'(ptpr_pkg::mulq(quat_x, quat_z, ptpr_pkg::QUAT_FRAC));
      s1_yz <= 34'(ptpr_pkg::mulq(quat_y, quat_z, ptpr_pkg::QUAT_FRAC));
      s1_xw <= 34'(ptpr_pkg::mulq(quat_x, quat_w, ptpr_pkg::QUAT_FRAC));
      s1_yw <= 34'(ptpr_pkg::mulq(quat_y, quat_w, ptpr_pkg::QUAT_FRAC));
      s1_zw <= 34'(ptpr_pkg::mulq(quat_z, quat_w, ptpr_pkg::QUAT_FRAC));
    end
  end

  // ---------------------------------------------------------------------
  // S2: rotation matrix, row major, each entry saturated Q2.30.
  // ---------------------------------------------------------------------
  logic signed [31:0] s2_r [0:8];
  logic signed [31:0] s2_p [0:2];
  logic signed [31:0] s2_n [0:2];
  logic signed [31:0] s2_d;
  logic [30:0]        s2_w;
  logic signed [31:0] s2_jt [0:2];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_r[0] <= ptpr_pkg::sat32(ptpr_pkg::QUAT_ONE - ((64'(s1_yy) + 64'(s1_zz)) <<< 1));
      s2_r[1] <= ptpr_pkg::sat32((64'(s1_xy) - 64'(s1_zw)) <<< 1);
      s2_r[2] <= ptpr_pkg::sat32((64'(s1_xz) + 64'(s1_yw)) <<< 1);
      s2_r[3] <= ptpr_pkg::sat32((64'(s1_xy) + 64'(s1_zw)) <<< 1);
      s2_r[4] <= ptpr_pkg::sat32(ptpr_pkg::QUAT_ONE - ((64'(s1_xx) + 64'(s1_zz)) <<< 1));
      s2_r[5] <= ptpr_pkg::sat32((64'(s1_yz) - 64'(s1_xw)) <<< 1);
      s2_r[6] <= ptpr_pkg::sat32((64'(s1_xz) - 64'(s1_yw)) <<< 1);
      s2_r[7] <= ptpr_pkg::sat32((64'(s1_yz) + 64'(s1_xw)) <<< 1);
      s2_r[8] <= ptpr_pkg::sat32(ptpr_pkg::QUAT_ONE - ((64'(s1_xx) + 64'(s1_yy)) <<< 1));
      s2_p  <= s1_p;
      s2_n  <= s1_n;
      s2_d  <= s1_d;
      s2_w  <= s1_w;
      s2_jt <= s1_jt;
    end
  end

  // ---------------------------------------------------------------------
  // S3: the nine R*p products, rounded to QP.
  // ---------------------------------------------------------------------
  logic signed [33:0] s3_rm [0:8];
  logic signed [31:0] s3_n [0:2];
  logic signed [31:0] s3_d;
  logic [30:0]        s3_w;
  logic signed [31:0] s3_jt [0:2];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s3_rm[3*i+j] <= 34'(ptpr_pkg::mulq(s2_r[3*i+j], s2_p[j], ptpr_pkg::QUAT_FRAC));
        end
      end
      s3_n  <= s2_n;
      s3_d  <= s2_d;
      s3_w  <= s2_w;
      s3_jt <= s2_jt;
    end
  end

  // ---------------------------------------------------------------------
  // S4: rotated point R*p, saturated per component.
  // ---------------------------------------------------------------------
  logic signed [31:0] s4_rp [0:2];
  logic signed [31:0] s4_n [0:2];
  logic signed [31:0] s4_d;
  logic [30:0]        s4_w;
  logic signed [31:0] s4_jt [0:2];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        s4_rp[i] <= ptpr_pkg::sat32(64'(s3_rm[3*i]) + 64'(s3_rm[3*i+1]) +
                                    64'(s3_rm[3*i+2]));
      end
      s4_n  <= s3_n;
      s4_d  <= s3_d;
      s4_w  <= s3_w;
      s4_jt <= s3_jt;
    end
  end

  // ---------------------------------------------------------------------
  // S5: world point p_w = t + R*p; cross product terms of (R*p) x n.
  // ---------------------------------------------------------------------
  logic signed [31:0] s5_pw [0:2];
  logic signed [33:0] s5_cp [0:5];
  logic signed [31:0] s5_n [0:2];
  logic signed [31:0] s5_d;
  logic [30:0]        s5_w;
  logic signed [31:0] s5_jt [0:2];

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_pw[0] <= ptpr_pkg::sat32(64'(pose_tx) + 64'(s4_rp[0]));
      s5_pw[1] <= ptpr_pkg::sat32(64'(pose_ty) + 64'(s4_rp[1]));
      s5_pw[2] <= ptpr_pkg::sat32(64'(pose_tz) + 64'(s4_rp[2]));
      // pairs per output: x = cp0 - cp1, y = cp2 - cp3, z = cp4 - cp5
      s5_cp[0] <= 34'(ptpr_pkg::mulq(s4_rp[1], s4_n[2], ptpr_pkg::QUAT_FRAC));
      s5_cp[1] <= 34'(ptpr_pkg::mulq(s4_rp[2], s4_n[1], ptpr_pkg::QUAT_FRAC));
      s5_cp[2] <= 34'(ptpr_pkg::mulq(s4_rp[2], s4_n[0], ptpr_pkg::QUAT_FRAC));
      s5_cp[3] <= 34'(ptpr_pkg::mulq(s4_rp[0], s4_n[2], ptpr_pkg::QUAT_FRAC));
      s5_cp[4] <= 34'(ptpr_pkg::mulq(s4_rp[0], s4_n[1], ptpr_pkg::QUAT_FRAC));
      s5_cp[5] <= 34'(ptpr_pkg::mulq(s4_rp[1], s4_n[0], ptpr_pkg::QUAT_FRAC));
      s5_n  <= s4_n;
      s5_d  <= s4_d;
      s5_w  <= s4_w;
      s5_jt <= s4_jt;
    end
  end

  // ---------------------------------------------------------------------
  // S6: n.p_w products; rotation Jacobian differences.
  // ---------------------------------------------------------------------
  logic signed [33:0] s6_np [0:2];
  logic signed [31:0] s6_jr [0:2];
  logic signed [31:0] s6_d;
  logic [30:0]        s6_w;
  logic signed [31:0] s6_jt [0:2];

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int i = 0; i < 3; i++) begin
        s6_np[i] <= 34'(ptpr_pkg::mulq(s5_n[i], s5_pw[i], ptpr_pkg::QUAT_FRAC));
        s6_jr[i] <= ptpr_pkg::sat32(64'(s5_cp[2*i]) - 64'(s5_cp[2*i+1]));
      end
      s6_d  <= s5_d;
      s6_w  <= s5_w;
      s6_jt <= s5_jt;
    end
  end

  // ---------------------------------------------------------------------
  // S7: unweighted distance, saturated.
  // ---------------------------------------------------------------------
  logic signed [31:0] s7_err;
  logic [30:0]        s7_w;
  logic signed [31:0] s7_jr [0:2];
  logic signed [31:0] s7_jt [0:2];

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s7_err <= ptpr_pkg::sat32(64'(s6_np[0]) + 64'(s6_np[1]) + 64'(s6_np[2]) +
                                64'(s6_d));
      s7_w  <= s6_w;
      s7_jr <= s6_jr;
      s7_jt <= s6_jt;
    end
  end

  // ---------------------------------------------------------------------
  // S8: weighting and the output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      residual <= ptpr_pkg::sat32(ptpr_pkg::mulq(s7_err, $signed({1'b0, s7_w}),
                                                 ptpr_pkg::FRAC_BITS));
      jac_tx <= s7_jt[0];
      jac_ty <= s7_jt[1];
      jac_tz <= s7_jt[2];
      jac_rx <= s7_jr[0];
      jac_ry <= s7_jr[1];
      jac_rz <= s7_jr[2];
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // Back pressure only arises from a full pipe behind a stalled output.
  a_stall_origin: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && (&vld)))
    else $error("input stalled without a full, stalled pipe");

  // A transaction taken into an empty pipe occupies the first stage.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (vld == '0)) |=> (vld[0] && $countones(vld) == 1))
    else $error("accepted transaction not in first stage");

  // Reset empties the pipe.
  a_reset: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipe not empty after reset");

endmodule

// ===== tb/point_to_plane_residual_top_test.sv =====
module point_to_plane_residual_top_test;

  localparam int CLK_PERIOD      = 20;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES      = 12;
  localparam int MAX_REPORTS     = 100;
  // Watchdog limit in clock periods; it leaves a wide margin over a full run.
  localparam int TIMEOUT_CYCLES  = 600000;

  // Index above the last register; writes to it must be ignored.
  localparam logic [2:0] REG_SPARE = 3'd7;

  localparam logic signed [31:0] MAXV  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV  = 32'sh8000_0000;
  localparam logic signed [31:0] P1    = 32'sd65536;       // 1.0 in Q16.16
  localparam logic signed [31:0] N1    = 32'sd1073741824;  // 1.0 in Q2.30
  localparam logic signed [31:0] QTR   = 32'sd759250125;   // cos(45 deg) in Q2.30
  localparam logic signed [31:0] JMAX  = 32'sd131072;      // largest normal seen as QP
  localparam logic [30:0]        W1    = 31'd65536;
  localparam logic [30:0]        WHALF = 31'd32768;
  localparam logic [30:0]        WMAX  = 31'h7FFF_FFFF;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] point_x, point_y, point_z;
    logic signed [31:0] normal_x, normal_y, normal_z;
    logic signed [31:0] plane_offset;
    logic [30:0]        weight;
  } plane_obs_t;

  typedef struct packed {
    logic signed [31:0] residual;
    logic signed [31:0] jac_tx, jac_ty, jac_tz;
    logic signed [31:0] jac_rx, jac_ry, jac_rz;
  } resid_jac_t;

  // One directed transaction; when known is set the result is typed in.
  typedef struct packed {
    plane_obs_t obs;
    logic       known;
    resid_jac_t want;
  } obs_row_t;

  typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_BLOCK} stall_mode_t;

  // Directed rows, all run with the pose left at reset (identity, no offset).
  localparam obs_row_t DIRECTED [0:14] = '{
    // everything zero
    '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0}},
    // unit point on the x and y axes against the matching unit normal
    '{'{P1, 0, 0, N1, 0, 0, 0, W1}, 1'b1, '{P1, P1, 0, 0, 0, 0, 0}},
    '{'{0, P1, 0, 0, N1, 0, 0, W1}, 1'b1, '{P1, 0, P1, 0, 0, 0, 0}},
    // z cross x gives y in the rotation Jacobian, point lies in the plane
    '{'{0, 0, P1, N1, 0, 0, 0, W1}, 1'b1, '{0, P1, 0, 0, 0, P1, 0}},
    // residual saturation, both signs
    '{'{0, 0, 0, 0, 0, 0, MAXV, WMAX}, 1'b1, '{MAXV, 0, 0, 0, 0, 0, 0}},
    '{'{0, 0, 0, 0, 0, 0, MINV, WMAX}, 1'b1, '{MINV, 0, 0, 0, 0, 0, 0}},
    // normal extremes, non-unit
    '{'{0, 0, 0, MAXV, MAXV, MAXV, 0, 0}, 1'b1, '{0, JMAX, JMAX, JMAX, 0, 0, 0}},
    '{'{0, 0, 0, MINV, MINV, MINV, 0, 0}, 1'b1, '{0, -JMAX, -JMAX, -JMAX, 0, 0, 0}},
    // rounding ties on the normal conversion go toward +inf
    '{'{0, 0, 0, 32'sd8192, -32'sd8192, -32'sd8193, 0, 0}, 1'b1,
      '{0, 32'sd1, 0, -32'sd1, 0, 0, 0}},
    // rounding ties on the weight product
    '{'{0, 0, 0, 0, 0, 0, 32'sd1, WHALF}, 1'b1, '{32'sd1, 0, 0, 0, 0, 0, 0}},
    '{'{0, 0, 0, 0, 0, 0, -32'sd1, WHALF}, 1'b1, '{0, 0, 0, 0, 0, 0, 0}},
    // intermediate saturation everywhere, then one mid-range row; results from the predictor
    '{'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, WMAX}, 1'b0, '0},
    '{'{MINV, MINV, MINV, MINV, MINV, MINV, MINV, WMAX}, 1'b0, '0},
    '{'{MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV, WMAX}, 1'b0, '0},
    '{'{-3 * P1, 2 * P1, -P1, 0, 0, N1, 5 * P1, 2 * W1}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  plane_obs_t obs_drv  = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] residual, jac_tx, jac_ty, jac_tz, jac_rx, jac_ry, jac_rz;

  // Shadow copy of the pose registers; quat_reg is x, y, z, w.
  logic signed [31:0] trans_reg [3];
  logic signed [31:0] quat_reg  [4];

  resid_jac_t pending_residuals [$];
  int         mismatches = 0;
  int         burst_left = 0;

  point_to_plane_residual_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .point_x      (obs_drv.point_x),
    .point_y      (obs_drv.point_y),
    .point_z      (obs_drv.point_z),
    .normal_x     (obs_drv.normal_x),
    .normal_y     (obs_drv.normal_y),
    .normal_z     (obs_drv.normal_z),
    .plane_offset (obs_drv.plane_offset),
    .weight       (obs_drv.weight),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .residual     (residual),
    .jac_tx       (jac_tx),
    .jac_ty       (jac_ty),
    .jac_tz       (jac_tz),
    .jac_rx       (jac_rx),
    .jac_ry       (jac_ry),
    .jac_rz       (jac_rz)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Round to nearest with ties toward +inf: add half an LSB, then floor.
  function automatic longint round_half_up(longint v, int s);
    if (s == 0) begin
      return v;
    end
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > SAT_HI) begin
      return SAT_HI;
    end
    if (v < SAT_LO) begin
      return SAT_LO;
    end
    return v;
  endfunction

  // Both operands stay in the 32-bit range, so the product fits in 64 bits.
  function automatic longint fxmul(longint a, longint b, int s);
    return round_half_up(a * b, s);
  endfunction

  function automatic resid_jac_t compute_residual_jac(plane_obs_t o);
    longint qx, qy, qz, qw, one, w, d, err;
    longint xx, yy, zz, xy, xz, yz, xw, yw, zw;
    longint rot [3][3];
    longint pt [3], nrm [3], rp [3], pw [3], jr [3];
    resid_jac_t y;
    qx  = longint'(quat_reg[0]);
    qy  = longint'(quat_reg[1]);
    qz  = longint'(quat_reg[2]);
    qw  = longint'(quat_reg[3]);
    one = longint'(1) <<< ptpr_pkg::QUAT_FRAC;
    pt[0]  = longint'($signed(o.point_x));
    pt[1]  = longint'($signed(o.point_y));
    pt[2]  = longint'($signed(o.point_z));
    nrm[0] = longint'($signed(o.normal_x));
    nrm[1] = longint'($signed(o.normal_y));
    nrm[2] = longint'($signed(o.normal_z));
    d      = longint'($signed(o.plane_offset));
    w      = longint'(o.weight);

    // No normalization: raw quaternion goes straight into the matrix.
    xx = fxmul(qx, qx, ptpr_pkg::QUAT_FRAC);
    yy = fxmul(qy, qy, ptpr_pkg::QUAT_FRAC);
    zz = fxmul(qz, qz, ptpr_pkg::QUAT_FRAC);
    xy = fxmul(qx, qy, ptpr_pkg::QUAT_FRAC);
    xz = fxmul(qx, qz, ptpr_pkg::QUAT_FRAC);
    yz = fxmul(qy, qz, ptpr_pkg::QUAT_FRAC);
    xw = fxmul(qx, qw, ptpr_pkg::QUAT_FRAC);
    yw = fxmul(qy, qw, ptpr_pkg::QUAT_FRAC);
    zw = fxmul(qz, qw, ptpr_pkg::QUAT_FRAC);
    rot[0][0] = clamp32(one - 2 * (yy + zz));
    rot[0][1] = clamp32(2 * (xy - zw));
    rot[0][2] = clamp32(2 * (xz + yw));
    rot[1][0] = clamp32(2 * (xy + zw));
    rot[1][1] = clamp32(one - 2 * (xx + zz));
    rot[1][2] = clamp32(2 * (yz - xw));
    rot[2][0] = clamp32(2 * (xz - yw));
    rot[2][1] = clamp32(2 * (yz + xw));
    rot[2][2] = clamp32(one - 2 * (xx + yy));

    for (int i = 0; i < 3; i++) begin
      rp[i] = clamp32(fxmul(rot[i][0], pt[0], ptpr_pkg::QUAT_FRAC) +
                      fxmul(rot[i][1], pt[1], ptpr_pkg::QUAT_FRAC) +
                      fxmul(rot[i][2], pt[2], ptpr_pkg::QUAT_FRAC));
      pw[i] = clamp32(longint'(trans_reg[i]) + rp[i]);
    end

    err = clamp32(fxmul(nrm[0], pw[0], ptpr_pkg::QUAT_FRAC) +
                  fxmul(nrm[1], pw[1], ptpr_pkg::QUAT_FRAC) +
                  fxmul(nrm[2], pw[2], ptpr_pkg::QUAT_FRAC) + d);

    jr[0] = clamp32(fxmul(rp[1], nrm[2], ptpr_pkg::QUAT_FRAC) -
                    fxmul(rp[2], nrm[1], ptpr_pkg::QUAT_FRAC));
    jr[1] = clamp32(fxmul(rp[2], nrm[0], ptpr_pkg::QUAT_FRAC) -
                    fxmul(rp[0], nrm[2], ptpr_pkg::QUAT_FRAC));
    jr[2] = clamp32(fxmul(rp[0], nrm[1], ptpr_pkg::QUAT_FRAC) -
                    fxmul(rp[1], nrm[0], ptpr_pkg::QUAT_FRAC));

    y.residual = 32'(clamp32(fxmul(err, w, ptpr_pkg::FRAC_BITS)));
    y.jac_tx   = 32'(clamp32(round_half_up(nrm[0],
                   ptpr_pkg::QUAT_FRAC - ptpr_pkg::FRAC_BITS)));
    y.jac_ty   = 32'(clamp32(round_half_up(nrm[1],
                   ptpr_pkg::QUAT_FRAC - ptpr_pkg::FRAC_BITS)));
    y.jac_tz   = 32'(clamp32(round_half_up(nrm[2],
                   ptpr_pkg::QUAT_FRAC - ptpr_pkg::FRAC_BITS)));
    y.jac_rx   = 32'(jr[0]);
    y.jac_ry   = 32'(jr[1]);
    y.jac_rz   = 32'(jr[2]);
    return y;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mixed-magnitude word: extremes, zero, full random or random within +-2^(span-1).
  function automatic logic signed [31:0] pick_word(int span);
    logic signed [31:0] r;
    r = $urandom;
    unique case ($urandom_range(0, 9))
      0:       return MAXV;
      1:       return MINV;
      2:       return '0;
      3, 4, 5: return r;
      default: return r >>> (32 - span);
    endcase
  endfunction

  // Random unit vector in Q2.30 over the first dims components.
  function automatic void rand_unit(input int dims,
                                    output logic signed [31:0] v0, v1, v2, v3);
    real c [4];
    real mag;
    mag = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = (i < dims) ? ($itor($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0 : 0.0;
      mag  = mag + c[i] * c[i];
    end
    if (mag < 1.0e-6) begin
      c[dims - 1] = 1.0;
      mag = 1.0;
    end
    mag = $sqrt(mag);
    v0 = $rtoi(c[0] / mag * 1073741824.0);
    v1 = $rtoi(c[1] / mag * 1073741824.0);
    v2 = $rtoi(c[2] / mag * 1073741824.0);
    v3 = $rtoi(c[3] / mag * 1073741824.0);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Sender: bursts of random length, mostly preceded by a random gap.
  // The expectation is queued at the edge where the transaction is taken.
  task automatic issue(plane_obs_t o, resid_jac_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    obs_drv  <= o;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_residuals.push_back(want);
  endtask

  // Hold the sender off until every queued result has come back.
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_residuals.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic signed [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    unique case (idx)
      ptpr_pkg::REG_POSE_TX: trans_reg[0] = val;
      ptpr_pkg::REG_POSE_TY: trans_reg[1] = val;
      ptpr_pkg::REG_POSE_TZ: trans_reg[2] = val;
      ptpr_pkg::REG_QUAT_X:  quat_reg[0]  = val;
      ptpr_pkg::REG_QUAT_Y:  quat_reg[1]  = val;
      ptpr_pkg::REG_QUAT_Z:  quat_reg[2]  = val;
      ptpr_pkg::REG_QUAT_W:  quat_reg[3]  = val;
      default: ;
    endcase
  endtask

  // Pose for one phase. Only called with the pipeline empty.
  task automatic load_pose(int phase);
    logic signed [31:0] v [8];
    unique case (phase)
      1: foreach (v[i]) v[i] = MAXV;
      2: foreach (v[i]) v[i] = MINV;
      3: begin
        // identity rotation, translation at the rails and zero
        v[ptpr_pkg::REG_POSE_TX] = MAXV;
        v[ptpr_pkg::REG_POSE_TY] = MINV;
        v[ptpr_pkg::REG_POSE_TZ] = '0;
        v[ptpr_pkg::REG_QUAT_X]  = '0;
        v[ptpr_pkg::REG_QUAT_Y]  = '0;
        v[ptpr_pkg::REG_QUAT_Z]  = '0;
        v[ptpr_pkg::REG_QUAT_W]  = N1;
      end
      4: begin
        // quarter turn about z
        v[ptpr_pkg::REG_POSE_TX] = $signed($urandom) >>> 10;
        v[ptpr_pkg::REG_POSE_TY] = $signed($urandom) >>> 10;
        v[ptpr_pkg::REG_POSE_TZ] = $signed($urandom) >>> 10;
        v[ptpr_pkg::REG_QUAT_X]  = '0;
        v[ptpr_pkg::REG_QUAT_Y]  = '0;
        v[ptpr_pkg::REG_QUAT_Z]  = QTR;
        v[ptpr_pkg::REG_QUAT_W]  = QTR;
      end
      default: begin
        v[ptpr_pkg::REG_POSE_TX] = pick_word(26);
        v[ptpr_pkg::REG_POSE_TY] = pick_word(26);
        v[ptpr_pkg::REG_POSE_TZ] = pick_word(26);
        if ($urandom_range(0, 4) < 3) begin
          rand_unit(4, v[ptpr_pkg::REG_QUAT_X], v[ptpr_pkg::REG_QUAT_Y],
                    v[ptpr_pkg::REG_QUAT_Z], v[ptpr_pkg::REG_QUAT_W]);
        end else begin
          // raw, usually far from unit length
          for (int i = ptpr_pkg::REG_QUAT_X; i <= ptpr_pkg::REG_QUAT_W; i++) begin
            v[i] = pick_word(31);
          end
        end
      end
    endcase
    for (int i = ptpr_pkg::REG_POSE_TX; i <= ptpr_pkg::REG_QUAT_W; i++) begin
      write_reg(3'(i), v[i]);
    end
    // an index past the last register must leave the pose alone
    write_reg(REG_SPARE, $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: out_stall follows a pattern whose mode is drawn anew every segment,
  // so stalls land on every stage of the pipeline at some point.
  // ---------------------------------------------------------------------------
  initial begin
    stall_mode_t mode;
    int          seg_len;
    int          blk_len;
    forever begin
      mode    = stall_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(5, 60);
      blk_len = $urandom_range(1, 20);
      for (int c = 0; c < seg_len; c++) begin
        @(negedge clk);
        unique case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_COIN:     out_stall <= 1'($urandom_range(0, 1));
          STALL_PERIODIC: out_stall <= (c % 3 == 0);
          STALL_BLOCK:    out_stall <= (c < blk_len);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every output transaction is compared with the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    resid_jac_t got;
    resid_jac_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{residual, jac_tx, jac_ty, jac_tz, jac_rx, jac_ry, jac_rz};
      if (pending_residuals.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, residual %0d",
                                  got.residual));
      end else begin
        want = pending_residuals.pop_front();
        check_field("residual", got.residual, want.residual);
        check_field("jac_tx", got.jac_tx, want.jac_tx);
        check_field("jac_ty", got.jac_ty, want.jac_ty);
        check_field("jac_tz", got.jac_tz, want.jac_tz);
        check_field("jac_rx", got.jac_rx, want.jac_rx);
        check_field("jac_ry", got.jac_ry, want.jac_ry);
        check_field("jac_rz", got.jac_rz, want.jac_rz);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plane_obs_t o;
    // shadow pose starts at the reset values: no offset, identity rotation
    foreach (trans_reg[i]) trans_reg[i] = '0;
    quat_reg[0] = '0;
    quat_reg[1] = '0;
    quat_reg[2] = '0;
    quat_reg[3] = N1;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows against the reset pose.
    foreach (DIRECTED[i]) begin
      issue(DIRECTED[i].obs,
            DIRECTED[i].known ? DIRECTED[i].want : compute_residual_jac(DIRECTED[i].obs));
    end
    wait_drain();

    // Random phases, each with its own pose. Three quarters of the
    // transactions are plausible scan data; the rest is raw noise.
    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      load_pose(phase);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // pause mid-phase until the pipeline is empty
        if (k == ITEMS_PER_PHASE / 2) begin
          wait_drain();
        end
        if ($urandom_range(0, 3) != 0) begin
          o.point_x      = $signed($urandom) >>> 8;
          o.point_y      = $signed($urandom) >>> 8;
          o.point_z      = $signed($urandom) >>> 8;
          rand_unit(3, o.normal_x, o.normal_y, o.normal_z, o.plane_offset);
          o.plane_offset = $signed($urandom) >>> 10;
          o.weight       = 31'($urandom_range(0, 1 << 18));
        end else begin
          o.point_x      = pick_word(24);
          o.point_y      = pick_word(24);
          o.point_z      = pick_word(24);
          o.normal_x     = pick_word(31);
          o.normal_y     = pick_word(31);
          o.normal_z     = pick_word(31);
          o.plane_offset = pick_word(24);
          o.weight       = 31'(pick_word(20));
        end
        issue(o, compute_residual_jac(o));
      end
      wait_drain();
    end

    // Let any stray output surface before the verdict.
    repeat (ptpr_pkg::NUM_STAGES + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog in case a transaction never completes.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
